// ===== rtl/hsv_to_rgb888_assert.svh =====
// Assertion macros for the HSV to RGB888 converter.
// Used by rtl/hsv_to_rgb888.sv; bodies are empty when SYNTH is defined.
`ifndef HSV_TO_RGB888_ASSERT_SVH
`define HSV_TO_RGB888_ASSERT_SVH

`ifndef SYNTH
`define HSV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("hsv_to_rgb888 assertion failed");
`define HSV_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("hsv_to_rgb888 assertion failed");
`else
`define HSV_ASSERT(lbl, clk, rstn, prop)
`define HSV_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

// ===== rtl/hsv_pkg.sv =====
// Shared constants and types for the HSV to RGB888 converter.
// No dependencies; imported by hsv_term and hsv_to_rgb888.
`timescale 1ns / 1ps

package hsv_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned IN_W      = FRAC_BITS + 2;
  localparam int unsigned V_W       = FRAC_BITS + 1;
  localparam int unsigned T_W       = FRAC_BITS + 3;
  localparam int unsigned W_W       = FRAC_BITS + 8;
  localparam int unsigned M_W       = 2 * FRAC_BITS + 1;
  localparam int unsigned HI_W      = W_W + V_W;
  localparam int unsigned LO_W      = W_W + FRAC_BITS;
  localparam int unsigned GREY_W    = IN_W + 8;

  localparam int unsigned ONE        = 1 << FRAC_BITS;
  localparam int unsigned GREY_LIMIT = (3 * ONE + 999) / 1000;
  localparam int unsigned CH_MAX     = 255;

  localparam logic [M_W-1:0] ONE_SQ = M_W'(1) << (2 * FRAC_BITS);

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_e;

endpackage

// ===== rtl/hsv_term.sv =====
// One channel term: floor(w * m / 2^(3*FRAC_BITS)) with two split products.
// Depends on hsv_pkg; products registered on en_i, term out of the registers.
`timescale 1ns / 1ps

module hsv_term import hsv_pkg::*; (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W_W-1:0] w_i,
  input  logic [M_W-1:0] m_i,
  output logic [7:0]     term_o
);

  logic [HI_W-1:0] hi_q, hi_d;
  logic [LO_W-1:0] lo_q, lo_d;
  logic [HI_W-1:0] sum;

  assign hi_d = HI_W'(w_i) * HI_W'(m_i[M_W-1:FRAC_BITS]);
  assign lo_d = LO_W'(w_i) * LO_W'(m_i[FRAC_BITS-1:0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign sum    = hi_q + HI_W'(lo_q[LO_W-1:FRAC_BITS]);
  assign term_o = sum[2*FRAC_BITS+7:2*FRAC_BITS];

endmodule

// ===== rtl/hsv_to_rgb888.sv =====
// HSV to RGB888 converter: four-stage pipeline that takes one pixel per clock
// when not stalled and gives its RGB word from the last stage. Depends on hsv_pkg,
// hsv_term and hsv_to_rgb888_assert.svh.
`timescale 1ns / 1ps
`include "hsv_to_rgb888_assert.svh"

// Converts unsigned Q2.16 hue, saturation and value to 8-bit red, green and
// blue at one word per cycle when not stalled, through four pipeline registers
// (wrap and sector, inner product, split scaling products, channel select). A
// stall holds each full stage with only full stages after it; empty stages
// still fill, so stall_o rises only when all four stages hold a word and
// stall_i is high. Saturation below 0.003 gives grey, floor(255*v) clamped.

module hsv_to_rgb888 import hsv_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  logic [IN_W-1:0] hue_i,
  input  logic [IN_W-1:0] saturation_i,
  input  logic [IN_W-1:0] brightness_i,
  output logic            valid_o,
  input  logic            stall_i,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o
);

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  assign en4     = !v4_q || !stall_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;
  assign valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: wrap, sector, grey
  logic [T_W-1:0]    t_d;
  logic [V_W-1:0]    s_d, v_d;
  logic [GREY_W-1:0] gprod;
  logic [7:0]        gval_d;
  logic              grey_d;
  logic [W_W-1:0]    w_d;

  sector_e            sec1_q;
  logic [FRAC_BITS-1:0] f1_q;
  logic [V_W-1:0]     s1_q;
  logic [W_W-1:0]     w1_q;
  logic               grey1_q;
  logic [7:0]         gval1_q;

  assign t_d    = T_W'(hue_i[FRAC_BITS-1:0]) * T_W'(6);
  assign s_d    = (saturation_i > IN_W'(ONE)) ? {1'b0, saturation_i[FRAC_BITS-1:0]}
                                              : saturation_i[V_W-1:0];
  assign v_d    = (brightness_i > IN_W'(ONE)) ? {1'b0, brightness_i[FRAC_BITS-1:0]}
                                              : brightness_i[V_W-1:0];
  assign grey_d = saturation_i < IN_W'(GREY_LIMIT);
  assign gprod  = GREY_W'(brightness_i) * GREY_W'(CH_MAX);
  assign gval_d = (gprod[GREY_W-1:FRAC_BITS] > (GREY_W - FRAC_BITS)'(CH_MAX))
                  ? 8'(CH_MAX) : gprod[FRAC_BITS+7:FRAC_BITS];
  assign w_d    = W_W'(v_d) * W_W'(CH_MAX);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sec1_q  <= sector_e'(t_d[T_W-1:FRAC_BITS]);
      f1_q    <= t_d[FRAC_BITS-1:0];
      s1_q    <= s_d;
      w1_q    <= w_d;
      grey1_q <= grey_d;
      gval1_q <= gval_d;
    end
  end

  // stage 2: inner terms 1 - s*x, scaled by 2^(2*FRAC_BITS)
  logic [V_W-1:0] nf;
  logic [M_W-1:0] m_low_d, m_fall_d, m_rise_d;

  sector_e        sec2_q;
  logic [M_W-1:0] m_low2_q, m_fall2_q, m_rise2_q;
  logic [W_W-1:0] w2_q;
  logic           grey2_q;
  logic [7:0]     gval2_q;

  assign nf       = V_W'(ONE) - {1'b0, f1_q};
  assign m_low_d  = ONE_SQ - {s1_q, {FRAC_BITS{1'b0}}};
  assign m_fall_d = ONE_SQ - M_W'(s1_q) * M_W'(nf);
  assign m_rise_d = ONE_SQ - M_W'(s1_q) * M_W'(f1_q);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sec2_q    <= sec1_q;
      m_low2_q  <= m_low_d;
      m_fall2_q <= m_fall_d;
      m_rise2_q <= m_rise_d;
      w2_q      <= w1_q;
      grey2_q   <= grey1_q;
      gval2_q   <= gval1_q;
    end
  end

  // stage 3: scaling products inside hsv_term
  logic [7:0] low3, fall3, rise3;
  sector_e    sec3_q;
  logic [7:0] full3_q;
  logic       grey3_q;
  logic [7:0] gval3_q;

  hsv_term u_low  (.clk_i(clk_i), .en_i(en3), .w_i(w2_q), .m_i(m_low2_q),  .term_o(low3));
  hsv_term u_fall (.clk_i(clk_i), .en_i(en3), .w_i(w2_q), .m_i(m_fall2_q), .term_o(fall3));
  hsv_term u_rise (.clk_i(clk_i), .en_i(en3), .w_i(w2_q), .m_i(m_rise2_q), .term_o(rise3));

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sec3_q  <= sec2_q;
      full3_q <= w2_q[FRAC_BITS+7:FRAC_BITS];
      grey3_q <= grey2_q;
      gval3_q <= gval2_q;
    end
  end

  // stage 4: channel select
  logic [7:0] red_d, green_d, blue_d;
  logic [7:0] red_q, green_q, blue_q;

  always_comb begin
    unique case (sec3_q)
      SEC_0: begin
        red_d = full3_q; green_d = fall3;   blue_d = low3;
      end
      SEC_1: begin
        red_d = rise3;   green_d = full3_q; blue_d = low3;
      end
      SEC_2: begin
        red_d = low3;    green_d = full3_q; blue_d = fall3;
      end
      SEC_3: begin
        red_d = low3;    green_d = rise3;   blue_d = full3_q;
      end
      SEC_4: begin
        red_d = fall3;   green_d = low3;    blue_d = full3_q;
      end
      default: begin
        red_d = full3_q; green_d = low3;    blue_d = rise3;
      end
    endcase
    if (grey3_q) begin
      red_d   = gval3_q;
      green_d = gval3_q;
      blue_d  = gval3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  `HSV_ASSERT(a_stall_full, clk_i, rst_ni, stall_o == (v1_q && v2_q && v3_q && v4_q && stall_i))
  `HSV_ASSERT_NEXT(a_accept_fill, clk_i, rst_ni, valid_i && !stall_o, v1_q)
  `HSV_ASSERT_NEXT(a_s2_hold, clk_i, rst_ni, v2_q && !en3, v2_q && $stable(sec2_q))
  `HSV_ASSERT_NEXT(a_s3_hold, clk_i, rst_ni, v3_q && !en4, v3_q && $stable(full3_q))

endmodule
